>>> rtl/core/vctp_pkg.sv
`default_nettype none
package vctp_pkg;

	localparam int REPLICAS_DEF = 32;
	localparam int POSITION_BITS_DEF = 16;
	localparam int POS_W_MAX = 32;

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// one record per item that gives results: an optional entry and an optional tail
	typedef struct packed {
		logic                 has_entry;
		logic                 has_tail;
		logic [1:0]           tail_kind;
		logic [4:0]           replica;
		logic [62:0]          count;
		logic [31:0]          map;
		logic [63:0]          sum;
		logic [POS_W_MAX-1:0] pos;
	} rec_t;

endpackage
`default_nettype wire

>>> rtl/core/vctp_front.sv
`default_nettype none
module vctp_front #(
	parameter int REPLICAS = 32,
	parameter int POSITION_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [7:0]        char_code,
	input  wire               first,
	input  wire               q_full,
	output logic              q_push,
	output vctp_pkg::rec_t    q_rec
);
	import vctp_pkg::*;

	localparam logic [2:0] PH_BEGIN = 3'd0;
	localparam logic [2:0] PH_KEY   = 3'd1;
	localparam logic [2:0] PH_SEP   = 3'd2;
	localparam logic [2:0] PH_VAL   = 3'd3;
	localparam logic [2:0] PH_COMMA = 3'd4;
	localparam logic [2:0] PH_END   = 3'd5;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [9:0] ID_MAX = 10'd63;
	localparam logic [6:0] REP_LIM = 7'(REPLICAS);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [2:0]               phase_q;
	logic                     in_number_q;
	logic [5:0]               id_q;
	logic                     id_ovf_q;
	logic [62:0]              cnt_q;
	logic                     cnt_ovf_q;
	logic [4:0]               rep_q;
	logic [REPLICAS-1:0]      seen_q;
	logic [REPLICAS-1:0]      nz_q;
	logic [63:0]              sum_q;
	logic [POSITION_BITS-1:0] idx_q;
	logic                     fin_q;

	// state as seen by this item, after the clear of a first character
	logic [2:0]               ph;
	logic                     innum;
	logic [5:0]               id;
	logic                     idov;
	logic [62:0]              cnt;
	logic                     cov;
	logic [4:0]               rep;
	logic [REPLICAS-1:0]      seen;
	logic [REPLICAS-1:0]      nz;
	logic [63:0]              sum;
	logic [POSITION_BITS-1:0] idx;
	logic                     fin;

	logic [2:0]               ph_n;
	logic                     innum_n;
	logic [5:0]               id_n;
	logic                     idov_n;
	logic [62:0]              cnt_n;
	logic                     cov_n;
	logic [4:0]               rep_n;
	logic [REPLICAS-1:0]      seen_n;
	logic [REPLICAS-1:0]      nz_n;
	logic [63:0]              sum_n;
	logic [POSITION_BITS-1:0] idx_n;
	logic                     fin_n;

	logic                     is_digit;
	logic                     is_blank;
	logic                     is_space;
	logic [3:0]               digit;
	logic [9:0]               id_prod;
	logic [66:0]              cnt_prod;
	logic [REPLICAS-1:0]      rep_bit;
	logic                     has_entry;
	logic                     err;
	logic                     done;
	logic                     accept;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
	assign is_space = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign digit    = 4'(char_code - CH_ZERO);

	always_comb begin
		ph    = first ? PH_BEGIN : phase_q;
		innum = first ? 1'b0 : in_number_q;
		id    = first ? '0 : id_q;
		idov  = first ? 1'b0 : id_ovf_q;
		cnt   = first ? '0 : cnt_q;
		cov   = first ? 1'b0 : cnt_ovf_q;
		rep   = first ? '0 : rep_q;
		seen  = first ? '0 : seen_q;
		nz    = first ? '0 : nz_q;
		sum   = first ? '0 : sum_q;
		idx   = first ? '0 : idx_q;
		fin   = first ? 1'b0 : fin_q;
	end

	// times ten as two shifts and an add
	assign id_prod  = ({4'b0, id} << 3) + ({4'b0, id} << 1) + {6'b0, digit};
	assign cnt_prod = ({4'b0, cnt} << 3) + ({4'b0, cnt} << 1) + {63'b0, digit};
	assign rep_bit  = REPLICAS'(1) << rep;

	always_comb begin
		ph_n      = ph;
		innum_n   = innum;
		id_n      = id;
		idov_n    = idov;
		cnt_n     = cnt;
		cov_n     = cov;
		rep_n     = rep;
		seen_n    = seen;
		nz_n      = nz;
		sum_n     = sum;
		idx_n     = idx;
		fin_n     = fin;
		has_entry = 1'b0;
		err       = 1'b0;
		done      = 1'b0;
		if (!fin) begin
			idx_n = (idx == POS_MAX) ? idx : idx + 1'b1;
			if (innum && is_digit) begin
				if (ph == PH_KEY) begin
					if (!idov && id_prod <= ID_MAX)
						id_n = id_prod[5:0];
					else
						idov_n = 1'b1;
				end else begin
					if (!cov && cnt_prod[66:63] == 4'b0)
						cnt_n = cnt_prod[62:0];
					else
						cov_n = 1'b1;
				end
			end else begin
				// the character that ends a number is checked, then parsed by the next phase
				if (innum) begin
					innum_n = 1'b0;
					if (ph == PH_KEY) begin
						if (idov || {1'b0, id} >= REP_LIM) begin
							err = 1'b1;
						end else begin
							rep_n = id[4:0];
							ph_n  = PH_SEP;
						end
					end else begin
						if (cov || (nz & rep_bit) != '0) begin
							err = 1'b1;
						end else begin
							seen_n = seen | rep_bit;
							if (cnt != '0)
								nz_n = nz | rep_bit;
							sum_n     = sum + 64'(cnt);
							has_entry = 1'b1;
							ph_n      = PH_COMMA;
						end
					end
				end
				if (!err) begin
					unique case (ph_n)
						PH_BEGIN: begin
							if (char_code == CH_LBRACE) ph_n = PH_KEY;
							else if (!is_blank) err = 1'b1;
						end
						PH_KEY: begin
							if (is_digit) begin
								innum_n = 1'b1;
								id_n    = {2'b0, digit};
								idov_n  = 1'b0;
							end else if (char_code == CH_RBRACE) ph_n = PH_END;
							else if (!is_blank) err = 1'b1;
						end
						PH_SEP: begin
							if (char_code == CH_COLON) ph_n = PH_VAL;
							else if (!is_blank) err = 1'b1;
						end
						PH_VAL: begin
							if (is_digit) begin
								innum_n = 1'b1;
								cnt_n   = {59'b0, digit};
								cov_n   = 1'b0;
							end else if (!is_blank) err = 1'b1;
						end
						PH_COMMA: begin
							if (char_code == CH_RBRACE) ph_n = PH_END;
							else if (char_code == CH_COMMA) ph_n = PH_KEY;
							else if (!is_space) err = 1'b1;
						end
						PH_END: begin
							if (char_code == CH_NUL) done = 1'b1;
							else if (!is_blank) err = 1'b1;
						end
						default: err = 1'b1;
					endcase
				end
			end
			fin_n = err || done;
		end
	end

	always_comb begin
		q_rec.has_entry = has_entry;
		q_rec.has_tail  = err || done;
		q_rec.tail_kind = err ? KIND_ERROR : KIND_DONE;
		q_rec.replica   = rep;
		q_rec.count     = cnt;
		q_rec.map       = done ? 32'(seen) : '0;
		q_rec.sum       = done ? sum : '0;
		q_rec.pos       = err ? POS_W_MAX'(idx_n) : '0;
	end

	assign q_push = accept && (has_entry || err || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BEGIN;
			in_number_q <= 1'b0;
			id_q        <= '0;
			id_ovf_q    <= 1'b0;
			cnt_q       <= '0;
			cnt_ovf_q   <= 1'b0;
			rep_q       <= '0;
			seen_q      <= '0;
			nz_q        <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			fin_q       <= 1'b0;
		end else if (accept) begin
			phase_q     <= ph_n;
			in_number_q <= innum_n;
			id_q        <= id_n;
			id_ovf_q    <= idov_n;
			cnt_q       <= cnt_n;
			cnt_ovf_q   <= cov_n;
			rep_q       <= rep_n;
			seen_q      <= seen_n;
			nz_q        <= nz_n;
			sum_q       <= sum_n;
			idx_q       <= idx_n;
			fin_q       <= fin_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vctp_queue.sv
`default_nettype none
module vctp_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  vctp_pkg::rec_t rec_in,
	input  wire            pop,
	output vctp_pkg::rec_t head,
	output logic           empty,
	output logic           full
);
	import vctp_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam logic [QPTR_W:0] QFULL = (QPTR_W+1)'(QDEPTH);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (fill_q == '0);
	assign full  = (fill_q == QFULL);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= rec_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/vctp_back.sv
`default_nettype none
module vctp_back #(
	parameter int POSITION_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  vctp_pkg::rec_t           head,
	input  wire                      empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic [1:0]               kind,
	output logic                     last,
	output logic [4:0]               replica,
	output logic [62:0]              count_value,
	output logic [31:0]              present_map,
	output logic [63:0]              total_sum,
	output logic [POSITION_BITS-1:0] error_position
);
	import vctp_pkg::*;

	logic                     out_valid_q;
	logic                     entry_done_q;
	logic [1:0]               kind_q;
	logic                     last_q;
	logic [4:0]               replica_q;
	logic [62:0]              count_q;
	logic [31:0]              map_q;
	logic [63:0]              sum_q;
	logic [POSITION_BITS-1:0] pos_q;

	logic load;
	logic take_entry;

	assign load       = !out_valid_q || !out_stall;
	assign take_entry = head.has_entry && !entry_done_q;
	// a record with an entry and a tail stays at the head for two results
	assign pop        = load && !empty && !(take_entry && head.has_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			entry_done_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty)
				entry_done_q <= take_entry && head.has_tail;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (take_entry) begin
				kind_q    <= KIND_ENTRY;
				last_q    <= !head.has_tail;
				replica_q <= head.replica;
				count_q   <= head.count;
				map_q     <= '0;
				sum_q     <= '0;
				pos_q     <= '0;
			end else begin
				kind_q    <= head.tail_kind;
				last_q    <= 1'b1;
				replica_q <= '0;
				count_q   <= '0;
				map_q     <= head.map;
				sum_q     <= head.sum;
				pos_q     <= head.pos[POSITION_BITS-1:0];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign last           = last_q;
	assign replica        = replica_q;
	assign count_value    = count_q;
	assign present_map    = map_q;
	assign total_sum      = sum_q;
	assign error_position = pos_q;

endmodule
`default_nettype wire

>>> rtl/core/vector_clock_text_parser_core.sv
`default_nettype none
// Parses text of the form {id: count, ...} one character per item, one item per clock
// while in_stall is low. The front parser updates its state once per accepted character
// (a times-ten accumulate and a 64-bit sum add) and hands every item that gives results
// to a four-record queue; the back end drives one result per cycle from its output
// register while out_stall is low, and the first result of an item is registered in the
// queue and then in the output register. A character that ends a count and then fails
// the comma phase gives two results; in_stall rises only while the queue is full. Stored
// entries, success (presence map and sum) or an error with the 1-based character
// position are reported; first restarts the parse.
module vector_clock_text_parser_core #(
	parameter int REPLICAS = vctp_pkg::REPLICAS_DEF,
	parameter int POSITION_BITS = vctp_pkg::POSITION_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire  [7:0]               char_code,
	input  wire                      first,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic [1:0]               kind,
	output logic                     last,
	output logic [4:0]               replica,
	output logic [62:0]              count_value,
	output logic [31:0]              present_map,
	output logic [63:0]              total_sum,
	output logic [POSITION_BITS-1:0] error_position
);
	import vctp_pkg::*;

	rec_t q_rec;
	rec_t q_head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	vctp_front #(
		.REPLICAS(REPLICAS),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.first(first),
		.q_full(q_full),
		.q_push(q_push),
		.q_rec(q_rec)
	);

	vctp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.rec_in(q_rec),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty),
		.full(q_full)
	);

	vctp_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.empty(q_empty),
		.pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.last(last),
		.replica(replica),
		.count_value(count_value),
		.present_map(present_map),
		.total_sum(total_sum),
		.error_position(error_position)
	);

`ifndef SYNTHESIS
	// an entry that is not last is followed at once by its tail result
	a_tail_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && last && kind != KIND_ENTRY))
		else $error("tail result missing after entry");

	a_hold_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |=> out_valid)
		else $error("output dropped between two results of one item");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

>>> bench/vector_clock_text_parser_core_tb.sv
module vector_clock_text_parser_core_tb;
	import vctp_pkg::*;

	localparam int REPL = REPLICAS_DEF;
	localparam int POS_W = POSITION_BITS_DEF;
	localparam logic [POS_W-1:0] POS_TOP = '1;
	localparam logic [63:0] COUNT_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int ID_TOP = 63;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;

	typedef enum logic [2:0] {
		AT_START, IN_ID, AT_COLON, IN_COUNT, AT_NEXT, AT_CLOSE
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] code;
		logic       fst;
		logic       calm;
	} text_char_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             last;
		logic [4:0]       replica;
		logic [62:0]      count;
		logic [31:0]      map;
		logic [63:0]      sum;
		logic [POS_W-1:0] position;
	} parse_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       char_code = '0;
	logic             first = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       kind;
	logic             last;
	logic [4:0]       replica;
	logic [62:0]      count_value;
	logic [31:0]      present_map;
	logic [63:0]      total_sum;
	logic [POS_W-1:0] error_position;

	text_char_t    text_queue[$];
	logic [7:0]    draft[$];
	parse_result_t results_due[$];
	parse_result_t step_results[$];

	// predicted parser state
	parse_phase_t     ph;
	bit               num_open;
	int               id_acc;
	bit               id_ovf;
	logic [63:0]      cnt_acc;
	bit               cnt_ovf;
	logic [4:0]       cur_rep;
	logic [31:0]      seen_reps;
	logic [31:0]      nonzero_reps;
	logic [63:0]      sum_acc;
	logic [POS_W-1:0] char_pos;
	bit               parse_done;

	int chars_taken = 0;
	int results_seen = 0;
	int entries_seen = 0;
	int maps_seen = 0;
	int errors_seen = 0;
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	int send_odds = 4;
	int recv_odds = 4;
	bit wind_down = 1'b0;
	bit holding = 1'b0;
	bit hold_used = 1'b0;
	text_char_t    next_char;
	parse_result_t want;

	always #2 clk = ~clk;

	vector_clock_text_parser_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.first          (first),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.last           (last),
		.replica        (replica),
		.count_value    (count_value),
		.present_map    (present_map),
		.total_sum      (total_sum),
		.error_position (error_position)
	);

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 4;
			default: return 16;
		endcase
	endfunction

	task automatic clear_parse();
		ph = AT_START;
		num_open = 1'b0;
		id_acc = 0;
		id_ovf = 1'b0;
		cnt_acc = '0;
		cnt_ovf = 1'b0;
		cur_rep = '0;
		seen_reps = '0;
		nonzero_reps = '0;
		sum_acc = '0;
		char_pos = '0;
		parse_done = 1'b0;
	endtask

	task automatic raise_error();
		parse_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.position = char_pos;
		parse_done = 1'b1;
		step_results.push_back(r);
	endtask

	// advances the predicted parser by one character and queues what it reports
	task automatic parse_char(input logic [7:0] c, input logic fst);
		parse_result_t r;
		int digit_val;
		logic [31:0] rep_bit;
		step_results.delete();
		if (fst)
			clear_parse();
		if (parse_done)
			return;
		if (char_pos != POS_TOP)
			char_pos++;
		digit_val = int'(c) - int'(CH_ZERO);
		if (num_open && is_digit(c)) begin
			if (ph == IN_ID) begin
				if (!id_ovf && id_acc * 10 + digit_val <= ID_TOP)
					id_acc = id_acc * 10 + digit_val;
				else
					id_ovf = 1'b1;
			end else begin
				if (!cnt_ovf && cnt_acc <= (COUNT_TOP - 64'(digit_val)) / 64'd10)
					cnt_acc = cnt_acc * 64'd10 + 64'(digit_val);
				else
					cnt_ovf = 1'b1;
			end
			return;
		end
		// the character that ends a number is checked here and then parsed below
		if (num_open) begin
			num_open = 1'b0;
			if (ph == IN_ID) begin
				if (id_ovf || id_acc >= REPL) begin
					raise_error();
				end else begin
					cur_rep = 5'(id_acc);
					ph = AT_COLON;
				end
			end else begin
				rep_bit = 32'd1 << cur_rep;
				if (cnt_ovf || (nonzero_reps & rep_bit) != 0) begin
					raise_error();
				end else begin
					seen_reps |= rep_bit;
					if (cnt_acc != 0)
						nonzero_reps |= rep_bit;
					sum_acc += cnt_acc;
					r = '0;
					r.kind = KIND_ENTRY;
					r.replica = cur_rep;
					r.count = cnt_acc[62:0];
					step_results.push_back(r);
					ph = AT_NEXT;
				end
			end
		end
		if (!parse_done) begin
			case (ph)
				AT_START: begin
					if (c == CH_OPEN)
						ph = IN_ID;
					else if (!is_blank(c))
						raise_error();
				end
				IN_ID: begin
					if (is_digit(c)) begin
						num_open = 1'b1;
						id_acc = digit_val;
						id_ovf = 1'b0;
					end else if (c == CH_CLOSE) begin
						ph = AT_CLOSE;
					end else if (!is_blank(c)) begin
						raise_error();
					end
				end
				AT_COLON: begin
					if (c == CH_COLON)
						ph = IN_COUNT;
					else if (!is_blank(c))
						raise_error();
				end
				IN_COUNT: begin
					if (is_digit(c)) begin
						num_open = 1'b1;
						cnt_acc = 64'(digit_val);
						cnt_ovf = 1'b0;
					end else if (!is_blank(c)) begin
						raise_error();
					end
				end
				AT_NEXT: begin
					if (c == CH_CLOSE)
						ph = AT_CLOSE;
					else if (c == CH_COMMA)
						ph = IN_ID;
					else if (!is_space(c))
						raise_error();
				end
				AT_CLOSE: begin
					if (c == CH_NUL) begin
						parse_done = 1'b1;
						r = '0;
						r.kind = KIND_DONE;
						r.map = seen_reps;
						r.sum = sum_acc;
						step_results.push_back(r);
					end else if (!is_blank(c)) begin
						raise_error();
					end
				end
				default: raise_error();
			endcase
		end
		foreach (step_results[i]) begin
			r = step_results[i];
			r.last = (i == step_results.size() - 1);
			results_due.push_back(r);
		end
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endtask

	task automatic put_blanks();
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3))
				draft.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	// after a count any whitespace is allowed, line breaks included
	task automatic put_gap();
		repeat ($urandom_range(0, 2))
			draft.push_back($urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4)));
	endtask

	task automatic commit_draft(input bit fst, input bit calm);
		foreach (draft[i])
			text_queue.push_back('{code: draft[i], fst: fst && i == 0, calm: calm});
		draft.delete();
	endtask

	function automatic string count_text();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0, 1, 2: return "0";
			3, 4, 5, 6: return $sformatf("%0d", $urandom_range(1, 999));
			7, 8: return $sformatf("%0d", v[31:0]);
			9, 10, 11: return $sformatf("%0d", v >> 1);
			12: return "9223372036854775807";
			13: return $sformatf("000%0d", v[15:0]);
			14: return $sformatf("%0d", v >> (1 + $urandom_range(0, 20)));
			default: begin
				if ($urandom_range(0, 1) == 0)
					return $sformatf("%0d", v | 64'h8000_0000_0000_0000);
				return "123456789012345678901234";
			end
		endcase
	endfunction

	task automatic draft_clock();
		int entries;
		int rep;
		logic [31:0] used;
		used = '0;
		entries = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 32) : $urandom_range(0, 5);
		put_blanks();
		draft.push_back(CH_OPEN);
		for (int k = 0; k < entries; k++) begin
			if (k > 0)
				draft.push_back(CH_COMMA);
			put_blanks();
			rep = $urandom_range(0, REPL - 1);
			for (int t = 0; t < 64 && used[rep]; t++)
				rep = $urandom_range(0, REPL - 1);
			case ($urandom_range(0, 24))
				0: rep = $urandom_range(REPL, 70);
				1: rep = $urandom_range(100, 9999);
				default: ;
			endcase
			if (rep < REPL)
				used[rep] = 1'b1;
			if ($urandom_range(0, 9) == 0)
				put_str("00");
			put_str($sformatf("%0d", rep));
			put_blanks();
			draft.push_back(CH_COLON);
			put_blanks();
			put_str(count_text());
			put_gap();
		end
		draft.push_back(CH_CLOSE);
		put_blanks();
		draft.push_back(CH_NUL);
	endtask

	// damage a drafted string: overwrite, drop, insert or cut short
	task automatic mangle_draft();
		int at;
		if (draft.size() == 0)
			return;
		at = $urandom_range(0, draft.size() - 1);
		case ($urandom_range(0, 3))
			0: draft[at] = 8'($urandom_range(0, 255));
			1: draft.delete(at);
			2: draft.insert(at, 8'($urandom_range(0, 255)));
			default: repeat (draft.size() - at) void'(draft.pop_back());
		endcase
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 200)
			$display("%0t: mismatch on result %0d: %s", $time, results_seen, what);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= '0;
			first <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				parse_char(char_code, first);
				chars_taken++;
			end
			if (!in_valid || !in_stall) begin
				if ($urandom_range(0, 299) == 0)
					send_odds = pick_odds();
				if (gap_left == 0 && !wind_down && !holding && send_odds != 0 &&
						$urandom_range(1, send_odds) == 1)
					gap_left = $urandom_range(1, 16);
				if (gap_left > 0 || text_queue.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					next_char = text_queue.pop_front();
					if (next_char.calm)
						wind_down = 1'b1;
					in_valid <= 1'b1;
					char_code <= next_char.code;
					first <= next_char.fst;
				end
			end
		end
	end

	// receiver stall, with one long hold-off so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (!hold_used && chars_taken >= 700) begin
				hold_used = 1'b1;
				holding = 1'b1;
				stall_left = 100;
			end
			if (stall_left == 0) begin
				holding = 1'b0;
				if ($urandom_range(0, 299) == 0)
					recv_odds = pick_odds();
				if (!wind_down && recv_odds != 0 && $urandom_range(1, recv_odds) == 1)
					stall_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			results_seen++;
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("kind %0d arrived with nothing due", kind));
			end else begin
				want = results_due.pop_front();
				if (want.kind == KIND_ENTRY)
					entries_seen++;
				else if (want.kind == KIND_DONE)
					maps_seen++;
				else
					errors_seen++;
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
				if (replica !== want.replica)
					report_mismatch($sformatf("replica %0d, expected %0d", replica, want.replica));
				if (count_value !== want.count)
					report_mismatch($sformatf("count_value %0h, expected %0h",
						count_value, want.count));
				if (present_map !== want.map)
					report_mismatch($sformatf("present_map %h, expected %h",
						present_map, want.map));
				if (total_sum !== want.sum)
					report_mismatch($sformatf("total_sum %h, expected %h", total_sum, want.sum));
				if (error_position !== want.position)
					report_mismatch($sformatf("error_position %0d, expected %0d",
						error_position, want.position));
			end
		end
	end

	initial begin
		clear_parse();

		// straight after reset, no first flag
		put_str("{3:7, 0:0}");
		draft.push_back(CH_NUL);
		commit_draft(1'b0, 1'b0);
		// top replica, top count, and a sum that wraps
		put_str("{31:9223372036854775807,0:9223372036854775807,1:9223372036854775807}");
		draft.push_back(CH_NUL);
		commit_draft(1'b1, 1'b0);
		// zero count given again, then a real one, any whitespace after a value
		put_str("{\t5 : 0 ,5:0,5:3\t\n\r}");
		draft.push_back(CH_NUL);
		commit_draft(1'b1, 1'b0);
		put_str("{2:1,2:4}");
		commit_draft(1'b1, 1'b0);
		// id out of range, then characters ignored until the next first
		put_str("{32:1}");
		draft.push_back(CH_NUL);
		put_str("{1:1}");
		draft.push_back(CH_NUL);
		commit_draft(1'b1, 1'b0);
		put_str("{999:1}");
		commit_draft(1'b1, 1'b0);
		put_str("{1:9223372036854775808}");
		commit_draft(1'b1, 1'b0);
		// entry and error from the same character
		put_str("{1:5x");
		commit_draft(1'b1, 1'b0);
		put_str("{4:6");
		draft.push_back(CH_NUL);
		commit_draft(1'b1, 1'b0);
		put_str("{1:2,\n3:4}");
		commit_draft(1'b1, 1'b0);
		put_str("{1 1:2}");
		commit_draft(1'b1, 1'b0);
		draft.push_back(8'hFF);
		commit_draft(1'b1, 1'b0);
		// restart part way through
		put_str("{7:");
		commit_draft(1'b1, 1'b0);
		put_str("{}");
		draft.push_back(CH_NUL);
		commit_draft(1'b1, 1'b0);

		while (text_queue.size() < 1620) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 12))
					text_queue.push_back('{code: 8'($urandom_range(0, 255)),
						fst: $urandom_range(0, 3) == 0, calm: 1'b0});
			end else begin
				draft_clock();
				if ($urandom_range(0, 5) == 0)
					mangle_draft();
				commit_draft($urandom_range(0, 9) != 0, 1'b0);
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 4))
						text_queue.push_back('{code: 8'($urandom_range(0, 255)), fst: 1'b0,
							calm: 1'b0});
			end
		end

		// closing stretch: a blank run that ends in a bad character, then a short clock
		draft.push_back(CH_OPEN);
		repeat ($urandom_range(20, 40))
			draft.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		draft.push_back(CH_HASH);
		commit_draft(1'b1, 1'b1);
		put_str("{7:1}");
		draft.push_back(CH_NUL);
		commit_draft(1'b1, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (text_queue.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d characters parsed, %0d results checked: %0d entries, %0d maps, %0d errors",
			chars_taken, results_seen, entries_seen, maps_seen, errors_seen);
		$display("covered hand-picked strings, damaged and noisy random clocks and a long"
			, " output hold-off that backs up the input");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4000000;
		$display("timed out with %0d characters queued and %0d results due",
			text_queue.size(), results_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
